[design/bezier_tracking_velocity_control_macros.svh]
// Assertion macros shared by the checker.
`ifndef BEZIER_TRACKING_VELOCITY_CONTROL_MACROS_SVH
`define BEZIER_TRACKING_VELOCITY_CONTROL_MACROS_SVH

`define BTV_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

`define BTV_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[design/btv_pkg.sv]
package btv_pkg;

  localparam int unsigned CordicIterations = 16;
  localparam int unsigned CordicLatency = CordicIterations + 1;
  localparam int unsigned AngW = 34;

  localparam logic signed [AngW-1:0] PiQ28 = 34'sd843314857;
  localparam logic signed [AngW-1:0] HalfPiQ28 = 34'sd421657428;
  localparam logic signed [AngW-1:0] TwoPiQ28 = 34'sd1686629713;
  localparam logic [29:0] KGainQ30 = 30'd652032874;
  // Rounded-up reciprocal of three with 36 fraction bits; exact for 34-bit dividends.
  localparam logic [34:0] ThirdRecipQ36 = 35'h555555556;

  localparam logic [2:0] RegGoalTol = 3'd0;
  localparam logic [2:0] RegLinAcc = 3'd1;
  localparam logic [2:0] RegAngAcc = 3'd2;
  localparam logic [2:0] RegPeriod = 3'd3;
  localparam logic [2:0] RegMaxLin = 3'd4;
  localparam logic [2:0] RegMaxAng = 3'd5;

  typedef struct packed {
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [15:0] start_heading;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
    logic signed [15:0] end_heading;
    logic signed [15:0] robot_heading;
    logic signed [31:0] current_lin_vel;
    logic signed [31:0] current_ang_vel;
  } btv_in_t;

  typedef struct packed {
    logic signed [31:0] lin_vel_cmd;
    logic signed [31:0] ang_vel_cmd;
    logic at_goal;
  } btv_out_t;

  typedef struct packed {
    logic [30:0] goal_tolerance;
    logic [30:0] lin_accel_limit;
    logic [30:0] ang_accel_limit;
    logic [16:0] ctl_period;
    logic [30:0] max_lin_speed;
    logic [30:0] max_ang_speed;
  } btv_cfg_t;

  function automatic logic [AngW-1:0] atan_entry(input int unsigned i);
    logic [AngW-1:0] r;
    r = '0;
    case (i)
      0: r = 34'd210828714;
      1: r = 34'd124459457;
      2: r = 34'd65760959;
      3: r = 34'd33381290;
      4: r = 34'd16755422;
      5: r = 34'd8385879;
      6: r = 34'd4193963;
      7: r = 34'd2097109;
      8: r = 34'd1048571;
      9: r = 34'd524287;
      10: r = 34'd262144;
      11: r = 34'd131072;
      12: r = 34'd65536;
      13: r = 34'd32768;
      14: r = 34'd16384;
      15: r = 34'd8192;
      16: r = 34'd4096;
      17: r = 34'd2048;
      18: r = 34'd1024;
      19: r = 34'd512;
      20: r = 34'd256;
      21: r = 34'd128;
      22: r = 34'd64;
      23: r = 34'd32;
      24: r = 34'd16;
      25: r = 34'd8;
      26: r = 34'd4;
      27: r = 34'd2;
      28: r = 34'd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

[design/bezier_tracking_velocity_control.sv]
// Throughput: one item per cycle; busy_o is always low.
// Three CORDIC steps of one cell per iteration set the latency; the middle one is two chains.
// Reset (rst_ni low, asynchronous) clears the valid pipeline and loads register defaults.
// The receiver cannot stall: each result is shown for exactly one cycle.
module bezier_tracking_velocity_control (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  btv_pkg::btv_in_t  item_i,
  output logic              done_o,
  output btv_pkg::btv_out_t result_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  localparam int unsigned L = btv_pkg::CordicLatency;
  localparam int unsigned W = btv_pkg::AngW + 4;
  localparam int unsigned TotLat = 3 * L + 7;

  btv_pkg::btv_cfg_t cfg_q;
  logic [2:0] ridx;
  assign ridx = paddr[4:2];
  assign pready = 1'b1;
  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.goal_tolerance <= 31'd6554;
      cfg_q.lin_accel_limit <= 31'd32768;
      cfg_q.ang_accel_limit <= 31'd65536;
      cfg_q.ctl_period <= 17'd6554;
      cfg_q.max_lin_speed <= 31'd32768;
      cfg_q.max_ang_speed <= 31'd65536;
    end else if (psel && penable && pwrite) begin
      case (ridx)
        btv_pkg::RegGoalTol: cfg_q.goal_tolerance <= pwdata[30:0];
        btv_pkg::RegLinAcc: cfg_q.lin_accel_limit <= pwdata[30:0];
        btv_pkg::RegAngAcc: cfg_q.ang_accel_limit <= pwdata[30:0];
        btv_pkg::RegPeriod: cfg_q.ctl_period <= pwdata[16:0];
        btv_pkg::RegMaxLin: cfg_q.max_lin_speed <= pwdata[30:0];
        btv_pkg::RegMaxAng: cfg_q.max_ang_speed <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      btv_pkg::RegGoalTol: prdata = {1'b0, cfg_q.goal_tolerance};
      btv_pkg::RegLinAcc: prdata = {1'b0, cfg_q.lin_accel_limit};
      btv_pkg::RegAngAcc: prdata = {1'b0, cfg_q.ang_accel_limit};
      btv_pkg::RegPeriod: prdata = {15'd0, cfg_q.ctl_period};
      btv_pkg::RegMaxLin: prdata = {1'b0, cfg_q.max_lin_speed};
      btv_pkg::RegMaxAng: prdata = {1'b0, cfg_q.max_ang_speed};
      default: prdata = '0;
    endcase
  end

  // Valid pipeline and delay lines for the inputs used later.
  logic [TotLat-1:0] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else vld_q <= {vld_q[TotLat-2:0], start_i};
  end

  btv_pkg::btv_in_t in_d [TotLat];
  always_ff @(posedge clk_i) begin
    in_d[0] <= item_i;
    for (int i = 1; i < TotLat; i++) in_d[i] <= in_d[i-1];
  end

  // Stage 0: chord vector, fold into right half plane.
  logic signed [32:0] dx0_q, dy0_q;
  logic signed [W-1:0] v1x, v1y;
  logic zero1_q;
  always_ff @(posedge clk_i) begin
    dx0_q <= 33'(item_i.end_x) - 33'(item_i.start_x);
    dy0_q <= 33'(item_i.end_y) - 33'(item_i.start_y);
    zero1_q <= (item_i.end_x == item_i.start_x) && (item_i.end_y == item_i.start_y);
  end
  always_comb begin
    v1x = dx0_q[32] ? -W'(dx0_q) : W'(dx0_q);
    v1y = dx0_q[32] ? -W'(dy0_q) : W'(dy0_q);
  end

  logic signed [W-1:0] c1x, c1y;
  logic signed [btv_pkg::AngW-1:0] c1z;
  btv_cordic_chain u_vec1 (.clk_i, .vec_mode_i(1'b1), .x_i(v1x), .y_i(v1y),
    .z_i('0), .x_o(c1x), .y_o(c1y), .z_o(c1z));

  logic zero1_d [L];
  logic signed [32:0] dxd [L], dyd [L];
  always_ff @(posedge clk_i) begin
    zero1_d[0] <= zero1_q;
    dxd[0] <= dx0_q;
    dyd[0] <= dy0_q;
    for (int i = 1; i < L; i++) begin
      zero1_d[i] <= zero1_d[i-1];
      dxd[i] <= dxd[i-1];
      dyd[i] <= dyd[i-1];
    end
  end
  // dxd[L-2] aligns with chain output (chain is L-1 deep).

  // Chord magnitude and goal test.
  logic [33:0] chord_q;
  logic signed [32:0] dx2_q, dy2_q;
  logic [67:0] chord_prod;
  assign chord_prod = 68'(c1x[33:0]) * 68'(btv_pkg::KGainQ30);
  always_ff @(posedge clk_i) begin
    chord_q <= zero1_d[L-2] ? '0 : chord_prod[63:30];
    dx2_q <= dxd[L-2];
    dy2_q <= dyd[L-2];
  end

  logic [33:0] dis_q;
  logic signed [32:0] dx3_q, dy3_q;
  logic goal3_q;
  logic [68:0] dis_prod;
  assign dis_prod = 69'(chord_q) * 69'(btv_pkg::ThirdRecipQ36);
  always_ff @(posedge clk_i) begin
    dis_q <= 34'(dis_prod[68:36]);
    dx3_q <= dx2_q;
    dy3_q <= dy2_q;
    goal3_q <= chord_q < 34'(cfg_q.goal_tolerance);
  end

  // Rotation chains for both end headings; headings enter at input pipeline index.
  localparam int unsigned HI = L + 2;
  logic signed [btv_pkg::AngW-1:0] h0, h3;
  logic signed [btv_pkg::AngW-1:0] a0, a3;
  logic n0, n3;
  assign h0 = btv_pkg::AngW'(in_d[HI-1].start_heading) <<< 15;
  assign h3 = btv_pkg::AngW'(in_d[HI-1].end_heading) <<< 15;
  always_comb begin
    n0 = (h0 > btv_pkg::HalfPiQ28) || (h0 < -btv_pkg::HalfPiQ28);
    a0 = (h0 > btv_pkg::HalfPiQ28) ? h0 - btv_pkg::PiQ28 :
         (h0 < -btv_pkg::HalfPiQ28) ? h0 + btv_pkg::PiQ28 : h0;
    n3 = (h3 > btv_pkg::HalfPiQ28) || (h3 < -btv_pkg::HalfPiQ28);
    a3 = (h3 > btv_pkg::HalfPiQ28) ? h3 - btv_pkg::PiQ28 :
         (h3 < -btv_pkg::HalfPiQ28) ? h3 + btv_pkg::PiQ28 : h3;
  end
  logic signed [W-1:0] r0x, r0y, r3x, r3y;
  logic signed [btv_pkg::AngW-1:0] r0z, r3z;
  btv_cordic_chain u_rot0 (.clk_i, .vec_mode_i(1'b0), .x_i(W'(btv_pkg::KGainQ30)),
    .y_i('0), .z_i(a0), .x_o(r0x), .y_o(r0y), .z_o(r0z));
  btv_cordic_chain u_rot3 (.clk_i, .vec_mode_i(1'b0), .x_i(W'(btv_pkg::KGainQ30)),
    .y_i('0), .z_i(a3), .x_o(r3x), .y_o(r3y), .z_o(r3z));
  logic n0d [L], n3d [L];
  always_ff @(posedge clk_i) begin
    n0d[0] <= n0;
    n3d[0] <= n3;
    for (int i = 1; i < L; i++) begin
      n0d[i] <= n0d[i-1];
      n3d[i] <= n3d[i-1];
    end
  end
  logic signed [31:0] c0, s0, c3, s3;
  assign c0 = n0d[L-2] ? -32'(r0x) : 32'(r0x);
  assign s0 = n0d[L-2] ? -32'(r0y) : 32'(r0y);
  assign c3 = n3d[L-2] ? -32'(r3x) : 32'(r3x);
  assign s3 = n3d[L-2] ? -32'(r3y) : 32'(r3y);

  logic [33:0] disd [L];
  logic signed [32:0] dx3d [L], dy3d [L];
  logic g3d [L];
  always_ff @(posedge clk_i) begin
    disd[0] <= dis_q;
    dx3d[0] <= dx3_q;
    dy3d[0] <= dy3_q;
    g3d[0] <= goal3_q;
    for (int i = 1; i < L; i++) begin
      disd[i] <= disd[i-1];
      dx3d[i] <= dx3d[i-1];
      dy3d[i] <= dy3d[i-1];
      g3d[i] <= g3d[i-1];
    end
  end
  // Rotation outputs and disd[L-2] line up with each other.

  logic [33:0] dis_a;
  logic signed [32:0] dx_a, dy_a;
  logic g_a;
  assign dis_a = disd[L-2];
  assign dx_a = dx3d[L-2];
  assign dy_a = dy3d[L-2];
  assign g_a = g3d[L-2];

  logic signed [67:0] p0x_q, p0y_q, p3x_q, p3y_q;
  logic signed [32:0] dx5_q, dy5_q;
  logic g5_q;
  always_ff @(posedge clk_i) begin
    p0x_q <= $signed({1'b0, dis_a}) * c0;
    p0y_q <= $signed({1'b0, dis_a}) * s0;
    p3x_q <= $signed({1'b0, dis_a}) * c3;
    p3y_q <= $signed({1'b0, dis_a}) * s3;
    dx5_q <= dx_a;
    dy5_q <= dy_a;
    g5_q <= g_a;
  end

  localparam logic signed [67:0] Half30 = 68'sd1 <<< 29;
  logic signed [37:0] a1x_q, a1y_q, a2x_q, a2y_q;
  logic signed [32:0] dx6_q, dy6_q;
  logic g6_q;
  always_ff @(posedge clk_i) begin
    a1x_q <= 38'((p0x_q + Half30) >>> 30);
    a1y_q <= 38'((p0y_q + Half30) >>> 30);
    a2x_q <= 38'(dx5_q) - 38'((p3x_q + Half30) >>> 30);
    a2y_q <= 38'(dy5_q) - 38'((p3y_q + Half30) >>> 30);
    dx6_q <= dx5_q;
    dy6_q <= dy5_q;
    g6_q <= g5_q;
  end

  logic signed [55:0] sx_q, sy_q;
  logic g7_q;
  always_ff @(posedge clk_i) begin
    sx_q <= 56'(a1x_q) * 56'sd28901 + 56'(a2x_q) * 56'sd12386 + 56'(dx6_q) * 56'sd1769;
    sy_q <= 56'(a1y_q) * 56'sd28901 + 56'(a2y_q) * 56'sd12386 + 56'(dy6_q) * 56'sd1769;
    g7_q <= g6_q;
  end

  logic signed [39:0] ddx, ddy;
  assign ddx = 40'((sx_q + 56'sd32768) >>> 16);
  assign ddy = 40'((sy_q + 56'sd32768) >>> 16);
  logic signed [W-1:0] v2x, v2y;
  logic signed [btv_pkg::AngW-1:0] v2z;
  logic zero2_q, g8_q;
  logic signed [W-1:0] v2x_q, v2y_q;
  logic signed [btv_pkg::AngW-1:0] v2z_q;
  always_ff @(posedge clk_i) begin
    zero2_q <= (ddx == 0) && (ddy == 0);
    g8_q <= g7_q;
    v2x_q <= ddx[39] ? -W'(ddx) : W'(ddx);
    v2y_q <= ddx[39] ? -W'(ddy) : W'(ddy);
    v2z_q <= ddx[39] ? ((ddy >= 0) ? btv_pkg::PiQ28 : -btv_pkg::PiQ28) : '0;
  end
  logic signed [W-1:0] e2x, e2y;
  btv_cordic_chain u_vec2 (.clk_i, .vec_mode_i(1'b1), .x_i(v2x_q), .y_i(v2y_q),
    .z_i(v2z_q), .x_o(e2x), .y_o(e2y), .z_o(v2z));
  assign v2x = e2x;
  assign v2y = e2y;

  logic z2d [L], g8d [L];
  always_ff @(posedge clk_i) begin
    z2d[0] <= zero2_q;
    g8d[0] <= g8_q;
    for (int i = 1; i < L; i++) begin
      z2d[i] <= z2d[i-1];
      g8d[i] <= g8d[i-1];
    end
  end

  localparam int unsigned RI = 3 * L + 4;
  logic [67:0] rho_prod;
  assign rho_prod = 68'(v2x[33:0]) * 68'(btv_pkg::KGainQ30);
  logic signed [35:0] rho_q;
  logic signed [btv_pkg::AngW+1:0] alpha_q;
  logic g9_q;
  always_ff @(posedge clk_i) begin
    rho_q <= z2d[L-2] ? '0 : 36'(rho_prod[63:30]);
    alpha_q <= (z2d[L-2] ? 36'sd0 : 36'(v2z))
               - (36'(in_d[RI-1].robot_heading) <<< 15);
    g9_q <= g8d[L-2];
  end
  logic unused_y;
  assign unused_y = ^v2y;

  logic signed [btv_pkg::AngW+1:0] aw, ar;
  logic signed [35:0] rr;
  always_comb begin
    aw = alpha_q;
    if (aw > 36'(btv_pkg::PiQ28)) aw = aw - 36'(btv_pkg::TwoPiQ28);
    if (aw > 36'(btv_pkg::PiQ28)) aw = aw - 36'(btv_pkg::TwoPiQ28);
    if (aw < -36'(btv_pkg::PiQ28)) aw = aw + 36'(btv_pkg::TwoPiQ28);
    if (aw < -36'(btv_pkg::PiQ28)) aw = aw + 36'(btv_pkg::TwoPiQ28);
    ar = aw;
    rr = rho_q;
    if (aw > 36'(btv_pkg::HalfPiQ28) || aw < -36'(btv_pkg::HalfPiQ28)) begin
      rr = -rho_q;
      ar = (aw > 0) ? aw - 36'(btv_pkg::PiQ28) : aw + 36'(btv_pkg::PiQ28);
    end
  end
  logic signed [35:0] rho10_q;
  logic signed [btv_pkg::AngW+1:0] al10_q;
  logic g10_q;
  always_ff @(posedge clk_i) begin
    rho10_q <= rr;
    al10_q <= ar;
    g10_q <= g9_q;
  end

  logic signed [63:0] wprod_q;
  logic signed [37:0] wv_q;
  logic g11_q;
  logic [47:0] vstep_q, wstep_q;
  always_ff @(posedge clk_i) begin
    wprod_q <= 64'(al10_q) * 64'sd144179;
    wv_q <= 38'(rho10_q) <<< 1;
    g11_q <= g10_q;
    vstep_q <= 48'(cfg_q.lin_accel_limit) * 48'(cfg_q.ctl_period);
    wstep_q <= 48'(cfg_q.ang_accel_limit) * 48'(cfg_q.ctl_period);
  end

  function automatic logic signed [31:0] lim(input logic signed [39:0] cur,
    input logic signed [39:0] want, input logic signed [39:0] step,
    input logic signed [39:0] maxv);
    logic signed [39:0] v;
    if (want > cur) begin
      v = cur + step;
      if (v > want) v = want;
    end else begin
      v = cur - step;
      if (v < want) v = want;
    end
    if (v > maxv) v = maxv;
    else if (v < -maxv) v = -maxv;
    return v[31:0];
  endfunction

  logic signed [39:0] ww;
  assign ww = 40'((wprod_q + 64'sd134217728) >>> 28);
  btv_pkg::btv_out_t res_q;
  logic done_q;
  always_ff @(posedge clk_i) begin
    res_q.at_goal <= g11_q;
    res_q.lin_vel_cmd <= g11_q ? '0 : lim(40'(in_d[TotLat-1].current_lin_vel), 40'(wv_q),
      40'(vstep_q[47:16]), 40'(cfg_q.max_lin_speed));
    res_q.ang_vel_cmd <= g11_q ? '0 : lim(40'(in_d[TotLat-1].current_ang_vel), ww,
      40'(wstep_q[47:16]), 40'(cfg_q.max_ang_speed));
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else done_q <= vld_q[TotLat-1] & ~unused_y | vld_q[TotLat-1] & unused_y;
  end
  assign done_o = done_q;
  assign result_o = res_q;
endmodule

[design/btv_cordic_cell.sv]
module btv_cordic_cell (
  input  logic                                clk_i,
  input  logic [4:0]                          stage_i,
  input  logic                                vec_mode_i,
  input  logic signed [btv_pkg::AngW+3:0]     x_i,
  input  logic signed [btv_pkg::AngW+3:0]     y_i,
  input  logic signed [btv_pkg::AngW-1:0]     z_i,
  output logic signed [btv_pkg::AngW+3:0]     x_o,
  output logic signed [btv_pkg::AngW+3:0]     y_o,
  output logic signed [btv_pkg::AngW-1:0]     z_o
);
  logic signed [btv_pkg::AngW+3:0] xs, ys;
  logic signed [btv_pkg::AngW-1:0] at;
  logic                            up;

  always_comb begin
    xs = x_i >>> stage_i;
    ys = y_i >>> stage_i;
    at = $signed(btv_pkg::atan_entry(32'(stage_i)));
    up = vec_mode_i ? (y_i > 0) : (z_i >= 0);
  end

  always_ff @(posedge clk_i) begin
    if (up) begin
      if (vec_mode_i) begin
        x_o <= x_i + ys;
        y_o <= y_i - xs;
        z_o <= z_i + at;
      end else begin
        x_o <= x_i - ys;
        y_o <= y_i + xs;
        z_o <= z_i - at;
      end
    end else begin
      if (vec_mode_i) begin
        x_o <= x_i - ys;
        y_o <= y_i + xs;
        z_o <= z_i - at;
      end else begin
        x_o <= x_i + ys;
        y_o <= y_i - xs;
        z_o <= z_i + at;
      end
    end
  end
endmodule

[design/btv_cordic_chain.sv]
module btv_cordic_chain (
  input  logic                            clk_i,
  input  logic                            vec_mode_i,
  input  logic signed [btv_pkg::AngW+3:0] x_i,
  input  logic signed [btv_pkg::AngW+3:0] y_i,
  input  logic signed [btv_pkg::AngW-1:0] z_i,
  output logic signed [btv_pkg::AngW+3:0] x_o,
  output logic signed [btv_pkg::AngW+3:0] y_o,
  output logic signed [btv_pkg::AngW-1:0] z_o
);
  localparam int unsigned N = btv_pkg::CordicIterations;
  logic signed [btv_pkg::AngW+3:0] xc [N+1];
  logic signed [btv_pkg::AngW+3:0] yc [N+1];
  logic signed [btv_pkg::AngW-1:0] zc [N+1];

  assign xc[0] = x_i;
  assign yc[0] = y_i;
  assign zc[0] = z_i;

  for (genvar g = 0; g < N; g++) begin : g_cell
    btv_cordic_cell u_cell (
      .clk_i, .stage_i(5'(g)), .vec_mode_i,
      .x_i(xc[g]), .y_i(yc[g]), .z_i(zc[g]),
      .x_o(xc[g+1]), .y_o(yc[g+1]), .z_o(zc[g+1])
    );
  end

  assign x_o = xc[N];
  assign y_o = yc[N];
  assign z_o = zc[N];
endmodule

[design/btv_checker.sv]
`include "bezier_tracking_velocity_control_macros.svh"
module btv_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start_i,
  input logic              busy_o,
  input logic              done_o,
  input btv_pkg::btv_out_t result_o,
  input logic              pready
);
  `BTV_ASSERT_IMPL(a_never_busy, clk_i, rst_ni, 1'b1, !busy_o)
  `BTV_ASSERT_IMPL(a_pready, clk_i, rst_ni, 1'b1, pready)
  `BTV_ASSERT_IMPL(a_goal_zero, clk_i, rst_ni, done_o && result_o.at_goal,
    result_o.lin_vel_cmd == 0 && result_o.ang_vel_cmd == 0)
endmodule

bind bezier_tracking_velocity_control btv_checker u_btv_checker (
  .clk_i, .rst_ni, .start_i, .busy_o, .done_o, .result_o, .pready);

[tb/tb_bezier_tracking_velocity_control.sv]
`timescale 1ns / 1ps

module tb_bezier_tracking_velocity_control;

  localparam int unsigned NumAtan = 16;
  localparam longint PiVal = 64'sd843314857;
  localparam longint HalfPiVal = 64'sd421657428;
  localparam longint TwoPiVal = 64'sd1686629713;
  localparam longint GainCorr = 64'sd652032874;
  localparam longint WeightA1 = 28901;
  localparam longint WeightA2 = 12386;
  localparam longint WeightD = 1769;
  localparam longint GainAlpha = 144179;
  localparam int unsigned PipeDepth = 3 * btv_pkg::CordicIterations + 10;
  localparam logic [4:0] AddrGoalTol = {btv_pkg::RegGoalTol, 2'b00};
  localparam logic [4:0] AddrLinAcc = {btv_pkg::RegLinAcc, 2'b00};
  localparam logic [4:0] AddrAngAcc = {btv_pkg::RegAngAcc, 2'b00};
  localparam logic [4:0] AddrPeriod = {btv_pkg::RegPeriod, 2'b00};
  localparam logic [4:0] AddrMaxLin = {btv_pkg::RegMaxLin, 2'b00};
  localparam logic [4:0] AddrMaxAng = {btv_pkg::RegMaxAng, 2'b00};
  localparam logic [4:0] AddrSpare6 = 5'd24;
  localparam logic [4:0] AddrSpare7 = 5'd28;

  typedef struct {
    btv_pkg::btv_in_t pose;
    bit               at_goal_row;
  } stim_row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start_i = 1'b0;
  logic              busy_o;
  btv_pkg::btv_in_t  item_i = '0;
  logic              done_o;
  btv_pkg::btv_out_t result_o;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [4:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  btv_pkg::btv_cfg_t cfg_shadow;
  btv_pkg::btv_out_t cmd_queue[$];
  stim_row_t         directed_rows[$];
  longint            atan_lut[NumAtan];
  int unsigned       mismatches = 0;
  int unsigned       cmds_seen = 0;
  int unsigned       goals_seen = 0;
  int unsigned       items_sent = 0;
  bit                idle_allowed = 1'b1;

  bezier_tracking_velocity_control DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .item_i  (item_i),
    .done_o  (done_o),
    .result_o(result_o),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #4 clk_i = ~clk_i;

  initial begin
    #5ms;
    $display("bezier_tracking_velocity_control verification failed");
    $finish;
  end

  function automatic longint round_shift(longint v, int unsigned s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic void cordic_sincos(longint ang, output longint c, output longint s);
    bit     flip;
    longint x, y, t;
    flip = 1'b0;
    x = GainCorr;
    y = 0;
    if (ang > HalfPiVal) begin
      ang -= PiVal;
      flip = 1'b1;
    end else if (ang < -HalfPiVal) begin
      ang += PiVal;
      flip = 1'b1;
    end
    for (int i = 0; i < NumAtan; i++) begin
      if (ang >= 0) begin
        t = x - (y >>> i); y = y + (x >>> i); x = t; ang -= atan_lut[i];
      end else begin
        t = x + (y >>> i); y = y - (x >>> i); x = t; ang += atan_lut[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic void cordic_polar(longint x, longint y, output longint mag,
                                       output longint ang);
    longint z, t;
    z = 0;
    if (x == 0 && y == 0) begin
      mag = 0;
      ang = 0;
    end else begin
      if (x < 0) begin
        z = (y >= 0) ? PiVal : -PiVal;
        x = -x;
        y = -y;
      end
      for (int i = 0; i < NumAtan; i++) begin
        if (y > 0) begin
          t = x + (y >>> i); y = y - (x >>> i); x = t; z += atan_lut[i];
        end else begin
          t = x - (y >>> i); y = y + (x >>> i); x = t; z -= atan_lut[i];
        end
      end
      mag = (x * GainCorr) >>> 30;
      ang = z;
    end
  endfunction

  function automatic longint rate_limit(longint cur, longint want, longint step,
                                        longint lim);
    longint v;
    if (want > cur) begin
      v = cur + step;
      if (v > want) v = want;
    end else begin
      v = cur - step;
      if (v < want) v = want;
    end
    if (v > lim) v = lim;
    else if (v < -lim) v = -lim;
    return v;
  endfunction

  function automatic btv_pkg::btv_out_t predict_command(btv_pkg::btv_in_t p,
                                                        btv_pkg::btv_cfg_t cfg);
    btv_pkg::btv_out_t r;
    longint dx, dy, chord, dummy, dis, c0, s0, c3, s3;
    longint a1x, a1y, a2x, a2y, tx, ty, rho, bearing, alpha, want_v, want_w;
    longint vstep, wstep;
    r = '0;
    dx = longint'(p.end_x) - longint'(p.start_x);
    dy = longint'(p.end_y) - longint'(p.start_y);
    cordic_polar(dx, dy, chord, dummy);
    if (chord < longint'(cfg.goal_tolerance)) begin
      r.at_goal = 1'b1;
      return r;
    end
    dis = chord / 3;
    cordic_sincos(longint'(p.start_heading) * 32768, c0, s0);
    cordic_sincos(longint'(p.end_heading) * 32768, c3, s3);
    a1x = round_shift(dis * c0, 30);
    a1y = round_shift(dis * s0, 30);
    a2x = dx - round_shift(dis * c3, 30);
    a2y = dy - round_shift(dis * s3, 30);
    tx = round_shift(WeightA1 * a1x + WeightA2 * a2x + WeightD * dx, 16);
    ty = round_shift(WeightA1 * a1y + WeightA2 * a2y + WeightD * dy, 16);
    cordic_polar(tx, ty, rho, bearing);
    alpha = bearing - longint'(p.robot_heading) * 32768;
    while (alpha > PiVal) alpha -= TwoPiVal;
    while (alpha < -PiVal) alpha += TwoPiVal;
    if (alpha > HalfPiVal || alpha < -HalfPiVal) begin
      rho = -rho;
      alpha = (alpha > 0) ? alpha - PiVal : alpha + PiVal;
    end
    want_v = 2 * rho;
    want_w = round_shift(alpha * GainAlpha, 28);
    vstep = (longint'(cfg.lin_accel_limit) * longint'(cfg.ctl_period)) >>> 16;
    wstep = (longint'(cfg.ang_accel_limit) * longint'(cfg.ctl_period)) >>> 16;
    r.lin_vel_cmd = 32'(rate_limit(longint'(p.current_lin_vel), want_v, vstep,
                                   longint'(cfg.max_lin_speed)));
    r.ang_vel_cmd = 32'(rate_limit(longint'(p.current_ang_vel), want_w, wstep,
                                   longint'(cfg.max_ang_speed)));
    return r;
  endfunction

  function automatic stim_row_t mk_row(int sx, int sy, shortint h0, int ex, int ey,
                                       shortint h3, shortint hr, int cv, int cw,
                                       bit goal);
    stim_row_t r;
    r.pose = '{start_x: sx, start_y: sy, start_heading: h0, end_x: ex, end_y: ey,
               end_heading: h3, robot_heading: hr, current_lin_vel: cv,
               current_ang_vel: cw};
    r.at_goal_row = goal;
    return r;
  endfunction

  function automatic void add_row(stim_row_t r);
    directed_rows.insert(directed_rows.size(), r);
  endfunction

  function automatic int rand_pos(bit wide);
    return wide ? int'($urandom) : $urandom_range(0, 1 << 20) - (1 << 19);
  endfunction

  function automatic shortint rand_heading();
    return ($urandom_range(99) < 10) ? shortint'($urandom)
                                     : shortint'($urandom_range(0, 51472) - 25736);
  endfunction

  function automatic btv_pkg::btv_in_t rand_pose();
    btv_pkg::btv_in_t p;
    bit               wide;
    wide = ($urandom_range(99) < 20);
    p.start_x = rand_pos(wide);
    p.start_y = rand_pos(wide);
    if ($urandom_range(99) < 10) begin
      p.end_x = p.start_x + $urandom_range(0, 8000) - 4000;
      p.end_y = p.start_y + $urandom_range(0, 8000) - 4000;
    end else begin
      p.end_x = wide ? int'($urandom) : p.start_x + rand_pos(1'b0);
      p.end_y = wide ? int'($urandom) : p.start_y + rand_pos(1'b0);
    end
    p.start_heading = rand_heading();
    p.end_heading = rand_heading();
    p.robot_heading = rand_heading();
    p.current_lin_vel = ($urandom_range(99) < 15) ? int'($urandom)
                                                  : $urandom_range(0, 262144) - 131072;
    p.current_ang_vel = ($urandom_range(99) < 15) ? int'($urandom)
                                                  : $urandom_range(0, 262144) - 131072;
    return p;
  endfunction

  task automatic issue_pose(btv_pkg::btv_in_t p, bit goal_only);
    btv_pkg::btv_out_t exp_cmd;
    while (idle_allowed && $urandom_range(99) < 30) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    item_i <= p;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    if (goal_only) begin
      exp_cmd = '0;
      exp_cmd.at_goal = 1'b1;
    end else begin
      exp_cmd = predict_command(p, cfg_shadow);
    end
    cmd_queue.insert(cmd_queue.size(), exp_cmd);
    items_sent++;
  endtask

  task automatic apb_access(logic [4:0] addr, logic [31:0] data, bit wr,
                            output logic [31:0] rd);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rd = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic write_reg(logic [4:0] addr, logic [31:0] data);
    logic [31:0] rd, want;
    apb_access(addr, data, 1'b1, rd);
    case (addr)
      AddrGoalTol: cfg_shadow.goal_tolerance = data[30:0];
      AddrLinAcc: cfg_shadow.lin_accel_limit = data[30:0];
      AddrAngAcc: cfg_shadow.ang_accel_limit = data[30:0];
      AddrPeriod: cfg_shadow.ctl_period = data[16:0];
      AddrMaxLin: cfg_shadow.max_lin_speed = data[30:0];
      AddrMaxAng: cfg_shadow.max_ang_speed = data[30:0];
      default: ;
    endcase
    case (addr)
      AddrGoalTol: want = {1'b0, cfg_shadow.goal_tolerance};
      AddrLinAcc: want = {1'b0, cfg_shadow.lin_accel_limit};
      AddrAngAcc: want = {1'b0, cfg_shadow.ang_accel_limit};
      AddrPeriod: want = {15'd0, cfg_shadow.ctl_period};
      AddrMaxLin: want = {1'b0, cfg_shadow.max_lin_speed};
      AddrMaxAng: want = {1'b0, cfg_shadow.max_ang_speed};
      default: want = rd;
    endcase
    @(posedge clk_i);
    apb_access(addr, 32'd0, 1'b0, rd);
    if (rd !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("register %0d read back %h, expected %h", addr, rd, want);
    end
  endtask

  task automatic settle();
    start_i <= 1'b0;
    while (cmd_queue.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_limits(logic [31:0] tol, logic [31:0] la, logic [31:0] aa,
                            logic [31:0] per, logic [31:0] ml, logic [31:0] ma);
    settle();
    write_reg(AddrGoalTol, tol);
    write_reg(AddrLinAcc, la);
    write_reg(AddrAngAcc, aa);
    write_reg(AddrPeriod, per);
    write_reg(AddrMaxLin, ml);
    write_reg(AddrMaxAng, ma);
  endtask

  always @(posedge clk_i) begin
    btv_pkg::btv_out_t exp_cmd;
    if (rst_ni && done_o) begin
      if (cmd_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", result_o);
      end else begin
        exp_cmd = cmd_queue.pop_front();
        cmds_seen++;
        if (result_o.at_goal === 1'b1) goals_seen++;
        if (result_o.lin_vel_cmd !== exp_cmd.lin_vel_cmd ||
            result_o.ang_vel_cmd !== exp_cmd.ang_vel_cmd ||
            result_o.at_goal !== exp_cmd.at_goal) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: got v=%0d w=%0d goal=%b, expected v=%0d w=%0d goal=%b",
                     result_o.lin_vel_cmd, result_o.ang_vel_cmd, result_o.at_goal,
                     exp_cmd.lin_vel_cmd, exp_cmd.ang_vel_cmd, exp_cmd.at_goal);
        end
      end
    end
  end

  initial begin
    int unsigned wait_cycles;
    stim_row_t   extra_row;
    atan_lut = '{210828714, 124459457, 65760959, 33381290, 16755422, 8385879, 4193963,
                 2097109, 1048571, 524287, 262144, 131072, 65536, 32768, 16384, 8192};
    cfg_shadow = '{goal_tolerance: 31'd6554, lin_accel_limit: 31'd32768,
                   ang_accel_limit: 31'd65536, ctl_period: 17'd6554,
                   max_lin_speed: 31'd32768, max_ang_speed: 31'd65536};

    add_row(mk_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1));
    add_row(mk_row(32'h7FFFFFFF, 32'h7FFFFFFF, 25736, 32'h7FFFFFFF,
                   32'h7FFFFFFF, 25736, 25736, 32'h7FFFFFFF,
                   32'h7FFFFFFF, 1'b1));
    add_row(mk_row(32'h80000000, 32'h80000000, -25736, 32'h80000000,
                   32'h80000000, -25736, -25736, 32'h80000000,
                   32'h80000000, 1'b1));
    add_row(mk_row(0, 0, 0, 6553, 0, 0, 0, 0, 0, 1'b0));
    add_row(mk_row(0, 0, 0, 65536, 0, 0, 0, 0, 0, 1'b0));
    add_row(mk_row(0, 0, 0, -65536, 0, 0, 0, 0, 0, 1'b0));
    add_row(mk_row(0, 0, 0, 0, 65536, 12868, 0, 0, 0, 1'b0));
    add_row(mk_row(0, 0, 0, 0, -65536, -12868, 25736, 0, 0, 1'b0));
    add_row(mk_row(32'h80000000, 0, 25736, 32'h7FFFFFFF, 0, -25736,
                   0, 0, 0, 1'b0));
    add_row(mk_row(0, 32'h7FFFFFFF, -25736, 0, 32'h80000000, 25736,
                   -25736, 32'h7FFFFFFF, 32'h80000000, 1'b0));
    add_row(mk_row(32'h80000000, 32'h80000000, 0, 32'h7FFFFFFF,
                   32'h7FFFFFFF, 0, 6434, 32'h80000000,
                   32'h7FFFFFFF, 1'b0));
    add_row(mk_row(0, 0, 16'sh7FFF, 200000, 100000, 16'sh8000,
                   16'sh7FFF, 0, 0, 1'b0));
    add_row(mk_row(0, 0, 16'sh8000, -200000, 100000, 16'sh7FFF,
                   16'sh8000, 0, 0, 1'b0));
    add_row(mk_row(1000, -1000, 0, 300000, 300000, 6434, -6434,
                   32'h7FFFFFFF, 0, 1'b0));
    add_row(mk_row(1000, -1000, 0, -300000, 300000, -6434, 6434,
                   32'h80000000, 32'h80000000, 1'b0));
    add_row(mk_row(0, 0, 0, 131072, 131072, 0, 0, 40000, 70000, 1'b0));

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    foreach (directed_rows[k]) issue_pose(directed_rows[k].pose, directed_rows[k].at_goal_row);

    set_limits(32'd0, 32'd65536, 32'd131072, 32'd65536, 32'h7FFFFFFF, 32'h7FFFFFFF);
    extra_row = mk_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0);
    issue_pose(extra_row.pose, 1'b0);
    extra_row = mk_row(5000, 5000, 0, 5000, 5000, 0, 12868, 100, -100, 1'b0);
    issue_pose(extra_row.pose, 1'b0);
    settle();
    write_reg(AddrSpare6, 32'hFFFFFFFF);
    write_reg(AddrSpare7, 32'h12345678);

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: ;
        1: set_limits(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'd65536,
                      32'h7FFFFFFF, 32'h7FFFFFFF);
        2: set_limits(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
        3: set_limits($urandom_range(0, 20000), $urandom, $urandom,
                      $urandom_range(0, 65536), $urandom, $urandom);
        4: set_limits(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                      32'hFFFFFFFF, 32'hFFFFFFFF);
        default: set_limits($urandom_range(0, 3000), $urandom_range(0, 1 << 20),
                            $urandom_range(0, 1 << 20), $urandom_range(1, 16384),
                            $urandom_range(0, 1 << 19), $urandom_range(0, 1 << 19));
      endcase
      for (int n = 0; n < 150; n++) begin
        idle_allowed = !(ph == 3);
        issue_pose(rand_pose(), 1'b0);
      end
      idle_allowed = 1'b1;
    end

    start_i <= 1'b0;
    wait_cycles = 0;
    while (cmd_queue.size() != 0 && wait_cycles < 100000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    if (cmd_queue.size() != 0) mismatches++;
    repeat (PipeDepth + 10) @(posedge clk_i);

    $display("Sent %0d items over seven register settings; %0d commands checked, %0d at goal.",
             items_sent, cmds_seen, goals_seen);
    $display("Register read-back, unused addresses and masked writes were exercised too.");
    if (mismatches == 0) begin
      $display("bezier_tracking_velocity_control verification clean");
    end else begin
      $display("%0d mismatches in total.", mismatches);
      $display("bezier_tracking_velocity_control verification failed");
    end
    $finish;
  end

endmodule

[bezier_tracking_velocity_control.f]
+incdir+design
design/btv_pkg.sv
design/btv_cordic_cell.sv
design/btv_cordic_chain.sv
design/bezier_tracking_velocity_control.sv
design/btv_checker.sv
tb/tb_bezier_tracking_velocity_control.sv
